@@ src/linear_probe_id_assigner_macros.svh @@
// assertion macros shared by the id assigner modules
`ifndef LINEAR_PROBE_ID_ASSIGNER_MACROS_SVH
`define LINEAR_PROBE_ID_ASSIGNER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define LPIA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define LPIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lpia_pkg.sv @@
// shared constants, types and codes of the linear probe id assigner
package lpia_pkg;

    localparam int KEY_W       = 64;
    // slot count; must be a power of two, the home slot is a mask of the magnitude
    localparam int TABLE_SIZE  = 1024;
    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int PROBE_LIMIT = TABLE_SIZE / 2;
    localparam int TRY_W       = $clog2(PROBE_LIMIT) + 1;

    // configuration register indices
    localparam logic CFG_BASE_OFFSET = 1'b0;
    localparam logic CFG_ERASE_MODE  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;   // write zero at the sweep pointer
        logic accept;   // load key, read home slot
        logic step;     // read next slot, count a miss
        logic finish;   // store slot, load found id
        logic give_up;  // load table-full result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic hit;
        logic empty;
        logic last_try;
    } t_sts;

endpackage

@@ src/lpia_dp.sv @@
// datapath of the id assigner: key memory, probe pointer, config and result registers
`include "linear_probe_id_assigner_macros.svh"

module lpia_dp import lpia_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [KEY_W-1:0] i_cfg_wdata,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic [KEY_W-1:0] o_feature_id,
    output logic             o_table_full
);

    logic [KEY_W-1:0] r_mem [TABLE_SIZE];
    logic [KEY_W-1:0] r_rdata;
    logic [KEY_W-1:0] r_key;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [TRY_W-1:0] r_tries;
    logic [IDX_W-1:0] r_clr_cnt;
    logic [KEY_W-1:0] r_base_offset;
    logic             r_erase_mode;
    logic [KEY_W-1:0] r_feature_id;
    logic             r_table_full;

    logic [IDX_W-1:0] home_idx;
    logic [IDX_W-1:0] idx_inc;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;

    // low bits of the magnitude: two's complement negation of the low bits
    assign home_idx = i_key[KEY_W-1] ? (~i_key[IDX_W-1:0] + IDX_W'(1)) : i_key[IDX_W-1:0];
    assign idx_inc  = (r_idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : r_idx + IDX_W'(1);
    assign n_idx    = i_cmd.accept ? home_idx : idx_inc;
    assign rd_en    = i_cmd.accept | i_cmd.step;

    assign wr_en   = i_cmd.clr_wr | i_cmd.finish;
    assign wr_addr = i_cmd.clr_wr ? r_clr_cnt : r_idx;
    // erase mode leaves the slot empty whether it was hit or just claimed
    assign wr_data = (i_cmd.clr_wr | r_erase_mode) ? '0 : r_key;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key <= i_key;
        end
        if (rd_en) begin
            r_idx <= n_idx;
        end
        if (i_cmd.finish) begin
            r_feature_id <= {{(KEY_W - IDX_W){1'b0}}, r_idx} + r_base_offset;
            r_table_full <= 1'b0;
        end else if (i_cmd.give_up) begin
            r_feature_id <= '0;
            r_table_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tries       <= '0;
            r_clr_cnt     <= '0;
            r_base_offset <= '0;
            r_erase_mode  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_tries <= '0;
            end else if (i_cmd.step) begin
                r_tries <= r_tries + TRY_W'(1);
            end
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + IDX_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_OFFSET: r_base_offset <= i_cfg_wdata;
                    CFG_ERASE_MODE:  r_erase_mode  <= i_cfg_wdata[0];
                    default:         r_erase_mode  <= r_erase_mode;
                endcase
            end
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == IDX_W'(TABLE_SIZE - 1));
    assign o_sts.hit      = (r_rdata == r_key);
    assign o_sts.empty    = (r_rdata == '0);
    assign o_sts.last_try = (r_tries == TRY_W'(PROBE_LIMIT - 1));

    assign o_feature_id = r_feature_id;
    assign o_table_full = r_table_full;

    `LPIA_ASSERT_NOW(a_step_below_limit, i_cmd.step, !o_sts.last_try, "probe stepped past limit")
    `LPIA_ASSERT_NEXT(a_step_advances, i_cmd.step, r_idx == $past(idx_inc), "probe pointer skipped")
    `LPIA_ASSERT_NOW(a_no_accept_during_clear, i_cmd.clr_wr, !i_cmd.accept,
        "word accepted during clear sweep")

endmodule

@@ src/lpia_ctrl.sv @@
// controller of the id assigner: clear sweep, probe sequencing and output handshake
`include "linear_probe_id_assigner_macros.svh"

module lpia_ctrl import lpia_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_sts.hit | i_sts.empty) begin
                    if (out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else if (i_sts.last_try) begin
                    if (out_free) begin
                        o_cmd.give_up = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        n_out_valid = (r_out_valid & ~i_m_tready) | o_cmd.finish | o_cmd.give_up;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    `LPIA_ASSERT_NOW(a_result_slot_free, o_cmd.finish || o_cmd.give_up, out_free,
        "result overwrote a waiting word")
    `LPIA_ASSERT_NOW(a_give_up_is_miss, o_cmd.give_up,
        i_sts.last_try && !i_sts.hit && !i_sts.empty, "gave up on a found slot")
    `LPIA_ASSERT_NEXT(a_accept_probes, o_cmd.accept, r_state == ST_PROBE,
        "accepted word not probed")

endmodule

@@ src/linear_probe_id_assigner.sv @@
// top level of the linear probe id assigner
//
// maps each signed 64-bit key to a dense id through an open-addressing table of 1024
// 64-bit slots with linear probing; the home slot is the key magnitude modulo the
// table size, an empty (zero) slot is claimed by writing the key, and the id is the
// slot index plus base_offset, wrapping at 64 bits. after reset the block sweeps the
// table to zero and takes no word meanwhile (config writes still land). each key is
// then accepted and probed slot by slot from its home slot, up to 512 slots, through
// the single read port of the key memory, which delivers one slot a cycle while
// probing. if the probe limit of half the table is reached the word comes back with
// table_full set, id 0, and the table unchanged. with erase_mode set the slot is
// emptied after the lookup. one result word per key; the result register lets the
// next key be accepted while a result still waits.
// base_offset and erase_mode must only be written while the block is idle
module linear_probe_id_assigner import lpia_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // key word in
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [KEY_W-1:0] i_s_tdata,    // [63:0] key
    // result word out
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [KEY_W-1:0] o_m_tdata,    // [63:0] feature_id
    output logic             o_m_tuser,    // [0] table_full
    // register writes: index 0 base_offset, index 1 erase_mode
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [KEY_W-1:0] i_cfg_wdata
);

    t_cmd cmd;    // controller commands to the datapath
    t_sts sts;    // compare and counter status back

    // sequencing: clear sweep, accept, probe loop, result hand-off
    lpia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table memory, probe pointer, config and result registers
    lpia_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (i_s_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_feature_id (o_m_tdata),
        .o_table_full (o_m_tuser)
    );

endmodule

@@ tb/linear_probe_id_assigner_tb.sv @@
// self-checking testbench for the linear probe id assigner, with its own table model
module linear_probe_id_assigner_tb;
    import lpia_pkg::*;

    // no-progress limit: the clearing pass, the long receiver hold-off and a full probe
    // of half the table fit in this many times over
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int FILL_HOMES  = 540;

    typedef struct packed {
        logic [KEY_W-1:0] id;
        logic             full;
    } t_id_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic [KEY_W-1:0] s_data = '0;
    logic             m_ready = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_index = CFG_BASE_OFFSET;
    logic [KEY_W-1:0] cfg_wdata = '0;
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [KEY_W-1:0] o_m_tdata;
    logic             o_m_tuser;

    // table model and its register copies
    logic [KEY_W-1:0] slot_model [TABLE_SIZE];
    logic [KEY_W-1:0] base_model = '0;
    logic             erase_model = 1'b0;

    logic [KEY_W-1:0] key_q [$];       // keys waiting to be offered
    logic [KEY_W-1:0] known_keys [$];  // every key sent so far, for repeat lookups
    t_id_result       pending_ids [$]; // expected result words, oldest first

    int   send_idle_pct = 22;
    int   recv_idle_pct = 22;
    logic hold_req = 1'b0;
    int   hold_left = 0;
    logic key_taken = 1'b0;
    int   quiet_cycles = 0;
    int   mismatches = 0;

    // driver-side scratch
    logic             nxt_valid;
    logic [KEY_W-1:0] nxt_data;
    logic             nxt_ready;
    logic             progress;
    t_id_result       got;
    t_id_result       want;

    linear_probe_id_assigner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),      // [63:0] key
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),   // [63:0] feature_id
        .o_m_tuser   (o_m_tuser),   // [0] table_full
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // linear probe from the home slot; claims an empty slot, gives up after half the table
    function automatic t_id_result map_key(logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] mag;
        logic [KEY_W-1:0] held;
        logic [IDX_W-1:0] idx;
        int               tries;
        logic             stop;
        logic             found;
        t_id_result       res;
        // the most negative key negates to itself, read unsigned that is 2^63
        mag   = key[KEY_W-1] ? (~key + 1'b1) : key;
        idx   = IDX_W'(mag % KEY_W'(TABLE_SIZE));
        tries = 0;
        stop  = 1'b0;
        found = 1'b0;
        while (!stop) begin
            held = slot_model[idx];
            if (held == '0) begin
                slot_model[idx] = key;
                found = 1'b1;
                stop  = 1'b1;
            end else if (held == key) begin
                found = 1'b1;
                stop  = 1'b1;
            end else begin
                tries++;
                if (tries >= PROBE_LIMIT) begin
                    stop = 1'b1;
                end else begin
                    // table size is a power of two, so the index wraps by itself
                    idx = idx + 1'b1;
                end
            end
        end
        if (!found) begin
            res.id   = '0;
            res.full = 1'b1;
        end else begin
            if (erase_model && slot_model[idx] == key) begin
                slot_model[idx] = '0;
            end
            res.id   = KEY_W'(idx) + base_model;
            res.full = 1'b0;
        end
        return res;
    endfunction

    // key whose magnitude lands on a chosen home slot, random upper bits and sign
    function automatic logic [KEY_W-1:0] key_at_home(int home);
        logic [KEY_W-1:0] rnd;
        logic [KEY_W-1:0] mag;
        rnd = {$urandom, $urandom};
        mag = {1'b0, rnd[KEY_W-2-IDX_W:0], IDX_W'(home)};
        return ($urandom_range(1) == 1) ? (~mag + 1'b1) : mag;
    endfunction

    task automatic send_key(logic [KEY_W-1:0] key);
        key_q.push_back(key);
        known_keys.push_back(key);
    endtask

    task automatic write_reg(logic idx, logic [KEY_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_BASE_OFFSET) begin
            base_model = value;
        end else begin
            erase_model = value[0];
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every key is taken and every result word is back
    task automatic drain();
        while (key_q.size() != 0 || s_valid || pending_ids.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // sender: keeps a word up until taken, idles only between words
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid && !key_taken;
            nxt_data  = s_data;
            key_taken = 1'b0;
            if (!nxt_valid && key_q.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt_data  = key_q.pop_front();
                nxt_valid = 1'b1;
            end
            s_valid <= nxt_valid;
            s_data  <= nxt_data;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else begin
            nxt_ready = ($urandom_range(99) >= recv_idle_pct);
        end
        m_ready <= nxt_ready;
    end

    // monitor: predicts on each taken key, checks each result word, watches for stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (s_valid && o_s_tready) begin
                pending_ids.push_back(map_key(s_data));
                key_taken = 1'b1;
                progress  = 1'b1;
            end
            if (o_m_tvalid && m_ready) begin
                progress = 1'b1;
                got.id   = o_m_tdata;
                got.full = o_m_tuser;
                if (pending_ids.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result word: id %h full %b", got.id, got.full);
                    end
                end else begin
                    want = pending_ids.pop_front();
                    if (got.id !== want.id || got.full !== want.full) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected id %h full %b, got id %h full %b",
                                     want.id, want.full, got.id, got.full);
                        end
                    end
                end
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("FAIL linear_probe_id_assigner");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            slot_model[i] = '0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // writes land during the clearing pass
        write_reg(CFG_BASE_OFFSET, '0);
        write_reg(CFG_ERASE_MODE, '0);

        // directed: collisions at the low end, extremes, wrap at the top slot, key zero
        send_key(64'd1);
        send_key(64'hFFFF_FFFF_FFFF_FFFF);          // -1, same home as 1
        send_key(64'h7FFF_FFFF_FFFF_FFFF);          // largest key, top slot
        send_key(64'h8000_0000_0000_0000);          // most negative key, home 0
        send_key(64'd0);                            // matches first empty slot, stays empty
        send_key(64'd1024);
        send_key(64'd1);
        send_key(64'hFFFF_FFFF_FFFF_FFFF);
        send_key(64'h8000_0000_0000_0000);
        send_key(64'd1023);                         // probe wraps past the top slot
        send_key(64'd0);
        drain();

        // id overflow at both ends of the offset range
        write_reg(CFG_BASE_OFFSET, 64'h7FFF_FFFF_FFFF_FFFF);
        send_key(64'd1);
        send_key(64'h7FFF_FFFF_FFFF_FFFF);
        drain();
        write_reg(CFG_BASE_OFFSET, 64'h8000_0000_0000_0000);
        send_key(64'hFFFF_FFFF_FFFF_FFFF);
        send_key(64'd0);
        drain();

        // erase of a held key, of a freshly claimed key, and of key zero
        write_reg(CFG_BASE_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_ERASE_MODE, {$urandom, $urandom} | 64'd1);
        send_key(64'hFFFF_FFFF_FFFF_FFFF);
        send_key(64'd1);
        send_key(64'd5555);
        send_key(64'd0);
        send_key(64'd5555);
        drain();

        // build a long cluster from slot 0 with no idling, then hold the receiver off
        write_reg(CFG_ERASE_MODE, {$urandom, $urandom} & ~64'd1);
        write_reg(CFG_BASE_OFFSET, {$urandom, $urandom});
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int h = 0; h < FILL_HOMES; h++) begin
            send_key(key_at_home(h));
        end
        @(posedge i_clk);
        hold_req = 1'b1;
        while (key_q.size() > FILL_HOMES / 2) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        send_idle_pct = 22;
        recv_idle_pct = 22;
        drain();

        // new keys homed deep in the cluster give up; known keys still held in the table hit
        for (int i = 0; i < 60; i++) begin
            if (i % 2 == 0) begin
                send_key(key_at_home($urandom_range(15)));
            end else begin
                send_key(known_keys[$urandom_range(known_keys.size() - 1)]);
            end
        end
        drain();

        // erase phase: mostly known keys, holes break some probe chains
        write_reg(CFG_ERASE_MODE, 64'd1);
        write_reg(CFG_BASE_OFFSET, {$urandom, $urandom});
        for (int i = 0; i < 60; i++) begin
            pick = $urandom_range(2);
            if (pick != 0) begin
                send_key(known_keys[$urandom_range(known_keys.size() - 1)]);
            end else begin
                send_key({$urandom, $urandom});
            end
        end
        drain();

        // noise: fully random keys and random homes
        write_reg(CFG_ERASE_MODE, 64'd0);
        write_reg(CFG_BASE_OFFSET, 64'd0);
        for (int i = 0; i < 40; i++) begin
            if (i % 3 == 0) begin
                send_key(key_at_home($urandom_range(TABLE_SIZE - 1)));
            end else begin
                send_key({$urandom, $urandom});
            end
        end
        drain();

        repeat (30) @(negedge i_clk);
        if (mismatches == 0 && pending_ids.size() == 0) begin
            $display("PASS linear_probe_id_assigner");
        end else begin
            $display("FAIL linear_probe_id_assigner");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/lpia_pkg.sv
src/lpia_dp.sv
src/lpia_ctrl.sv
src/linear_probe_id_assigner.sv
tb/linear_probe_id_assigner_tb.sv
